// ===== rtl/core/fcull_pkg.sv =====
package fcull_pkg;

  // sizes
  localparam int PLANE_COUNT = 6;
  localparam int MAT_DEPTH   = 16;
  localparam int PLN_DEPTH   = PLANE_COUNT * 4;
  localparam int MAT_AW      = $clog2(MAT_DEPTH);
  localparam int PLN_AW      = $clog2(PLN_DEPTH);
  localparam logic [31:0] Q_ONE = 32'd65536;

  typedef logic signed [31:0] q_t;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REBUILD = 2'd1,
    CMD_BOX     = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_LOAD,
    T_REBUILD,
    T_BOX
  } top_st_t;

  typedef enum logic [2:0] {
    RB_IDLE,
    RB_RD,
    RB_SUM,
    RB_SQ,
    RB_SQRT,
    RB_DIV,
    RB_WR
  } rb_st_t;

  localparam logic signed [47:0] MAX48 = 48'sd2147483647;
  localparam logic signed [47:0] MIN48 = -48'sd2147483648;
  localparam logic signed [32:0] MAX33 = 33'sd2147483647;
  localparam logic signed [32:0] MIN33 = -33'sd2147483648;

  // clamp to Q16.16
  function automatic q_t sat48(input logic signed [47:0] x);
    q_t r;
    if (x > MAX48) r = 32'sh7FFF_FFFF;
    else if (x < MIN48) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic q_t sat33(input logic signed [32:0] x);
    q_t r;
    if (x > MAX33) r = 32'sh7FFF_FFFF;
    else if (x < MIN33) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // magnitude, min value maps to 2^31
  function automatic logic [31:0] mag32(input q_t x);
    logic [31:0] r;
    r = x[31] ? (~x + 32'd1) : x;
    return r;
  endfunction

endpackage

// ===== rtl/core/fcull_ram.sv =====
module fcull_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fcull_rebuild.sv =====
module fcull_rebuild (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       done,
  output logic [fcull_pkg::MAT_AW-1:0] mat_raddr,
  input  fcull_pkg::q_t              mat_rdata,
  output logic                       pln_we,
  output logic [fcull_pkg::PLN_AW-1:0] pln_waddr,
  output fcull_pkg::q_t              pln_wdata
);
  import fcull_pkg::*;

  rb_st_t st_r, st_nxt;
  logic [5:0]  cnt_r;
  logic [2:0]  p_r;
  logic [1:0]  j_r;
  q_t          w_r [4];
  q_t          e_r [4];
  q_t          v_r [4];
  logic [63:0] ss_r;
  logic [31:0] root_r;
  logic [33:0] rem_r;
  logic [31:0] len_r;
  logic [47:0] dvd_r;
  logic [31:0] drem_r;

  logic [2:0]  cap_idx;
  logic [35:0] sq_rem;
  logic [35:0] sq_trial;
  logic        sq_ge;
  logic [31:0] root_new;
  logic [32:0] dv_sh;
  logic        dv_ge;
  logic [31:0] mag_sq;
  logic [1:0]  j_next;

  // matrix column that pairs with column 3 for each plane
  function automatic logic [1:0] col_sel(input logic [2:0] p);
    logic [1:0] c;
    unique case (p)
      3'd0, 3'd1: c = 2'd0;
      3'd2, 3'd3: c = 2'd1;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

  // row-sum / row-difference per plane, or the paired column alone for plane 4
  function automatic q_t plane_term(input logic [2:0] p, input q_t w, input q_t e);
    logic signed [32:0] s;
    unique case (p)
      3'd0, 3'd3: s = {w[31], w} + {e[31], e};
      3'd4:       s = {e[31], e};
      default:    s = {w[31], w} - {e[31], e};
    endcase
    return sat33(s);
  endfunction

  assign cap_idx   = cnt_r[2:0] - 3'd1;
  assign mat_raddr = {cnt_r[2:1], cnt_r[0] ? col_sel(p_r) : 2'd3};

  // one root digit a step
  assign sq_rem   = {rem_r, ss_r[63:62]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = (sq_rem >= sq_trial);
  assign root_new = {root_r[30:0], sq_ge};

  // one quotient bit a step
  assign dv_sh = {drem_r, dvd_r[47]};
  assign dv_ge = (dv_sh >= {1'b0, len_r});

  assign mag_sq = mag32(v_r[cnt_r[1:0]]);
  assign j_next = j_r + 2'd1;

  assign pln_waddr = {p_r, j_r};

  // saturated signed quotient
  always_comb begin
    if (v_r[j_r][31]) begin
      pln_wdata = (dvd_r > 48'd2147483648) ? 32'sh8000_0000 : -dvd_r[31:0];
    end else begin
      pln_wdata = (dvd_r > 48'd2147483647) ? 32'sh7FFF_FFFF : dvd_r[31:0];
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    pln_we = 1'b0;
    unique case (st_r)
      RB_IDLE: if (start) st_nxt = RB_RD;
      RB_RD:   if (cnt_r == 6'd8) st_nxt = RB_SUM;
      RB_SUM:  st_nxt = RB_SQ;
      RB_SQ:   if (cnt_r == 6'd2) st_nxt = RB_SQRT;
      RB_SQRT: if (cnt_r == 6'd31) st_nxt = RB_DIV;
      RB_DIV:  if (cnt_r == 6'd47) st_nxt = RB_WR;
      RB_WR: begin
        pln_we = 1'b1;
        if (j_r == 2'd3 && p_r == 3'(PLANE_COUNT - 1)) begin
          done   = 1'b1;
          st_nxt = RB_IDLE;
        end else if (j_r == 2'd3) begin
          st_nxt = RB_RD;
        end else begin
          st_nxt = RB_DIV;
        end
      end
      default: st_nxt = RB_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= RB_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      RB_IDLE: begin
        cnt_r <= '0;
        p_r   <= '0;
        j_r   <= '0;
      end
      RB_RD: begin
        if (cnt_r != 6'd0) begin
          if (cap_idx[0]) e_r[cap_idx[2:1]] <= mat_rdata;
          else            w_r[cap_idx[2:1]] <= mat_rdata;
        end
        cnt_r <= (cnt_r == 6'd8) ? 6'd0 : cnt_r + 6'd1;
      end
      RB_SUM: begin
        for (int i = 0; i < 4; i++) begin
          v_r[i] <= plane_term(p_r, w_r[i], e_r[i]);
        end
        ss_r  <= '0;
        cnt_r <= '0;
      end
      RB_SQ: begin
        ss_r  <= ss_r + {32'd0, mag_sq} * {32'd0, mag_sq};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd2) begin
          cnt_r  <= '0;
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      RB_SQRT: begin
        rem_r  <= sq_ge ? 34'(sq_rem - sq_trial) : sq_rem[33:0];
        root_r <= root_new;
        ss_r   <= {ss_r[61:0], 2'b00};
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          len_r  <= (root_new == 32'd0) ? Q_ONE : root_new;
          j_r    <= '0;
          dvd_r  <= {mag32(v_r[0]), 16'd0};
          drem_r <= '0;
          cnt_r  <= '0;
        end
      end
      RB_DIV: begin
        drem_r <= dv_ge ? 32'(dv_sh - {1'b0, len_r}) : dv_sh[31:0];
        dvd_r  <= {dvd_r[46:0], dv_ge};
        cnt_r  <= (cnt_r == 6'd47) ? 6'd0 : cnt_r + 6'd1;
      end
      RB_WR: begin
        cnt_r <= '0;
        if (j_r == 2'd3) begin
          j_r <= '0;
          p_r <= p_r + 3'd1;
        end else begin
          j_r    <= j_next;
          dvd_r  <= {mag32(v_r[j_next]), 16'd0};
          drem_r <= '0;
        end
      end
      default: cnt_r <= '0;
    endcase
  end

endmodule

// ===== rtl/core/fcull_box.sv =====
module fcull_box (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [31:0]           center_x,
  input  logic signed [31:0]           center_y,
  input  logic signed [31:0]           center_z,
  input  logic [30:0]                  extent_x,
  input  logic [30:0]                  extent_y,
  input  logic [30:0]                  extent_z,
  output logic [fcull_pkg::PLN_AW-1:0] pln_raddr,
  input  fcull_pkg::q_t                pln_rdata,
  output logic                         res_strobe,
  output logic                         res_visible
);
  import fcull_pkg::*;

  localparam logic [PLN_AW-1:0] LAST = PLN_AW'(PLN_DEPTH - 1);

  q_t                 c_r [3];
  logic [30:0]        e_r [3];
  logic [PLN_AW-1:0]  iss_r;
  logic               iss_on_r;
  logic               s1_v_r;
  logic [PLN_AW-1:0]  s1_idx_r;
  logic               s2_v_r;
  logic [PLN_AW-1:0]  s2_idx_r;
  logic signed [63:0] pd_r;
  logic [62:0]        pr_r;
  q_t                 d_r;
  logic signed [35:0] acc_d_r;
  logic [35:0]        acc_r_r;
  logic               cull_r;

  q_t                 csel;
  logic [30:0]        esel;
  q_t                 term_d;
  q_t                 term_r;
  logic signed [35:0] fin;
  logic               cull_now;

  assign pln_raddr = iss_r;

  // operand for this component; d carries no product
  always_comb begin
    unique case (s1_idx_r[1:0])
      2'd0:    begin csel = c_r[0]; esel = e_r[0]; end
      2'd1:    begin csel = c_r[1]; esel = e_r[1]; end
      2'd2:    begin csel = c_r[2]; esel = e_r[2]; end
      default: begin csel = '0;     esel = '0;     end
    endcase
  end

  // floor shift and clamp of the products
  assign term_d   = sat48(pd_r[63:16]);
  assign term_r   = sat48({1'b0, pr_r[62:16]});
  assign fin      = acc_d_r + 36'(d_r);
  assign cull_now = fin < -$signed(acc_r_r);

  assign res_strobe  = s2_v_r && (s2_idx_r == LAST);
  assign res_visible = !(cull_r || cull_now);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_on_r <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      s1_v_r <= iss_on_r;
      s2_v_r <= s1_v_r;
      if (start) begin
        iss_on_r <= 1'b1;
      end else if (iss_r == LAST) begin
        iss_on_r <= 1'b0;
      end
    end
  end

  // read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      c_r[0]  <= center_x;
      c_r[1]  <= center_y;
      c_r[2]  <= center_z;
      e_r[0]  <= extent_x;
      e_r[1]  <= extent_y;
      e_r[2]  <= extent_z;
      iss_r   <= '0;
      acc_d_r <= '0;
      acc_r_r <= '0;
      cull_r  <= 1'b0;
    end else begin
      if (iss_on_r && iss_r != LAST) iss_r <= iss_r + 1'b1;
      if (s2_v_r) begin
        if (s2_idx_r[1:0] == 2'd3) begin
          cull_r  <= cull_r | cull_now;
          acc_d_r <= '0;
          acc_r_r <= '0;
        end else begin
          acc_d_r <= acc_d_r + 36'(term_d);
          acc_r_r <= acc_r_r + {4'd0, term_r};
        end
      end
    end
    s1_idx_r <= iss_r;
    s2_idx_r <= s1_idx_r;
    pd_r     <= pln_rdata * csel;
    pr_r     <= {32'd0, esel} * {31'd0, mag32(pln_rdata)};
    d_r      <= pln_rdata;
  end

endmodule

// ===== rtl/core/frustum_aabb_culler.sv =====
// channel  | ports                                  | handshake
// input    | in_command .. in_extent_z              | start high, busy low
// result   | out_visible                            | out_strobe, one cycle
//
// Load: the four elements of a row, one matrix element per cycle into the matrix RAM.
// Box test: one plane RAM read per cycle over 24 entries, feeding
//   three stages of read, multiply and accumulate.
// Rebuild: for each of the six planes, matrix reads, a sum of squares, the
//   bit-serial square root and the 48-step divider once per coefficient.
// Reset (rst_n low, synchronous) clears control and all valid bits; RAM
//   entries not yet written read as zero. Results cannot be stalled.
module frustum_aabb_culler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [1:0]         in_row_index,
  input  logic signed [31:0] in_row_col0,
  input  logic signed [31:0] in_row_col1,
  input  logic signed [31:0] in_row_col2,
  input  logic signed [31:0] in_row_col3,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic [30:0]        in_extent_x,
  input  logic [30:0]        in_extent_y,
  input  logic [30:0]        in_extent_z,
  output logic               out_strobe,
  output logic               out_visible
);
  import fcull_pkg::*;

  top_st_t st_r, st_nxt;
  logic             accept;
  logic             rb_start;
  logic             rb_done;
  logic             box_start;
  logic [1:0]       row_r;
  logic [1:0]       cnt_r;
  q_t               cols_r [4];

  logic             mat_we;
  logic [MAT_AW-1:0] mat_waddr;
  logic [MAT_AW-1:0] mat_raddr;
  q_t               mat_rdata_raw;
  q_t               mat_rdata;
  logic [MAT_DEPTH-1:0] mat_vld_r;
  logic             mat_rv_r;

  logic             pln_we;
  logic [PLN_AW-1:0] pln_waddr;
  q_t               pln_wdata;
  logic [PLN_AW-1:0] pln_raddr;
  q_t               pln_rdata_raw;
  q_t               pln_rdata;
  logic [PLN_DEPTH-1:0] pln_vld_r;
  logic             pln_rv_r;

  assign busy      = (st_r != T_IDLE);
  assign accept    = start && !busy;
  assign rb_start  = accept && (in_command == CMD_REBUILD);
  assign box_start = accept && (in_command == CMD_BOX);

  // command dispatch
  always_comb begin
    st_nxt = st_r;
    mat_we = 1'b0;
    unique case (st_r)
      T_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_command))
            CMD_LOAD:    st_nxt = T_LOAD;
            CMD_REBUILD: st_nxt = T_REBUILD;
            CMD_BOX:     st_nxt = T_BOX;
            default:     st_nxt = T_IDLE;
          endcase
        end
      end
      T_LOAD: begin
        mat_we = 1'b1;
        if (cnt_r == 2'd3) st_nxt = T_IDLE;
      end
      T_REBUILD: if (rb_done) st_nxt = T_IDLE;
      T_BOX:     if (out_strobe) st_nxt = T_IDLE;
      default:   st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // row load beat: latch, then one element a cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r     <= in_row_index;
      cols_r[0] <= in_row_col0;
      cols_r[1] <= in_row_col1;
      cols_r[2] <= in_row_col2;
      cols_r[3] <= in_row_col3;
      cnt_r     <= '0;
    end else if (mat_we) begin
      cnt_r <= cnt_r + 2'd1;
    end
  end

  assign mat_waddr = {row_r, cnt_r};

  // valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_vld_r <= '0;
      pln_vld_r <= '0;
      mat_rv_r  <= 1'b0;
      pln_rv_r  <= 1'b0;
    end else begin
      if (mat_we) mat_vld_r[mat_waddr] <= 1'b1;
      if (pln_we) pln_vld_r[pln_waddr] <= 1'b1;
      mat_rv_r <= mat_vld_r[mat_raddr];
      pln_rv_r <= pln_vld_r[pln_raddr];
    end
  end

  assign mat_rdata = mat_rv_r ? mat_rdata_raw : '0;
  assign pln_rdata = pln_rv_r ? pln_rdata_raw : '0;

  fcull_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (cols_r[cnt_r]),
    .raddr (mat_raddr),
    .rdata (mat_rdata_raw)
  );

  fcull_ram #(.WIDTH(32), .DEPTH(PLN_DEPTH)) u_pln_ram (
    .clk   (clk),
    .we    (pln_we),
    .waddr (pln_waddr),
    .wdata (pln_wdata),
    .raddr (pln_raddr),
    .rdata (pln_rdata_raw)
  );

  fcull_rebuild u_rebuild (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rb_start),
    .done      (rb_done),
    .mat_raddr (mat_raddr),
    .mat_rdata (mat_rdata),
    .pln_we    (pln_we),
    .pln_waddr (pln_waddr),
    .pln_wdata (pln_wdata)
  );

  fcull_box u_box (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (box_start),
    .center_x    (in_center_x),
    .center_y    (in_center_y),
    .center_z    (in_center_z),
    .extent_x    (in_extent_x),
    .extent_y    (in_extent_y),
    .extent_z    (in_extent_z),
    .pln_raddr   (pln_raddr),
    .pln_rdata   (pln_rdata),
    .res_strobe  (out_strobe),
    .res_visible (out_visible)
  );

  // checks
  a_strobe_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> st_r == T_BOX) else $error("result outside box test");

  a_plane_wr_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    pln_we |-> st_r == T_REBUILD) else $error("plane write outside rebuild");

  a_mat_wr_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    mat_we |-> st_r == T_LOAD) else $error("matrix write outside load");

  a_busy_after_box: assert property (@(posedge clk) disable iff (!rst_n)
    box_start |=> busy && !out_strobe) else $error("box beat not taken");

endmodule
